// ----- rtl/wcs_pkg.sv -----
// ----------------------------------------------------------------------------
// wcs_pkg
// Shared constants, types and helper functions of the wall column shader.
// ----------------------------------------------------------------------------
package wcs_pkg;

	localparam int MAX_HEIGHT   = 4096;
	localparam int DOOR_COLOURS = 4;
	localparam int ROW_W        = 13;
	localparam int COL_W        = 12;
	localparam int RATE_W       = 16;
	localparam int DIV_BITS     = 15;
	localparam int DEN_W        = 50;
	localparam int ONE_SHIFT    = 42;
	localparam int RATE_MAX     = 13107;
	localparam int DOOR_IDX_MAX = (DOOR_COLOURS - 1 < 3) ? DOOR_COLOURS - 1 : 3;

	localparam logic [1:0] CFG_FADE   = 2'd0;
	localparam logic [1:0] CFG_GAIN   = 2'd1;
	localparam logic [1:0] CFG_HEIGHT = 2'd2;

	typedef enum logic [2:0] {
		MODE_OPEN,
		MODE_EDGE,
		MODE_WALL,
		MODE_DOOR2,
		MODE_DOOR3
	} mode_t;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] top;
		logic [ROW_W-1:0] bot;
		logic [ROW_W-1:0] e1;
		logic [ROW_W-1:0] e2;
		mode_t            mode;
		logic [1:0]       idx;
	} geo_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	function automatic rgb_t door_colour(input logic [1:0] idx);
		rgb_t c;
		case (idx)
			2'd0:    c = '{r: 8'd128, g: 8'd86,  b: 8'd64};
			2'd1:    c = '{r: 8'd16,  g: 8'd28,  b: 8'd164};
			2'd2:    c = '{r: 8'd8,   g: 8'd160, b: 8'd24};
			default: c = '{r: 8'd180, g: 8'd0,   b: 8'd0};
		endcase
		return c;
	endfunction

	function automatic logic [ROW_W-1:0] clamp_row(input logic signed [17:0] y,
			input logic [ROW_W-1:0] lim);
		logic [ROW_W-1:0] r;
		if (y < 0) r = '0;
		else if (y > $signed({5'b0, lim})) r = lim;
		else r = y[ROW_W-1:0];
		return r;
	endfunction

	// round half up, saturate at 255
	function automatic logic [7:0] chan(input logic [7:0] c, input logic [RATE_W-1:0] rate);
		logic [24:0] p;
		logic [10:0] v;
		p = 25'({17'b0, c} * {9'b0, rate}) + 25'd8192;
		v = p[24:14];
		return (v > 11'd255) ? 8'd255 : v[7:0];
	endfunction

endpackage

// ----- rtl/wcs_div.sv -----
// ----------------------------------------------------------------------------
// wcs_div
// Pipelined restoring divider: round(2^42 / den), one quotient bit per stage.
// ----------------------------------------------------------------------------
module wcs_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [wcs_pkg::DEN_W-1:0]    in_den,
	input  wcs_pkg::geo_t                in_geo,
	output logic                         out_valid,
	output logic [wcs_pkg::DIV_BITS-1:0] out_q,
	output wcs_pkg::geo_t                out_geo
);
	import wcs_pkg::*;

	localparam int SH_W = DEN_W + DIV_BITS - 1;

	logic                v_s   [DIV_BITS];
	logic [DEN_W-1:0]    rem_s [DIV_BITS];
	logic [DEN_W-1:0]    den_s [DIV_BITS];
	logic [DIV_BITS-1:0] quo_s [DIV_BITS];
	geo_t                geo_s [DIV_BITS];

	logic [DEN_W-1:0]    src_rem [DIV_BITS];
	logic [DEN_W-1:0]    src_den [DIV_BITS];
	logic [DIV_BITS-1:0] src_quo [DIV_BITS];
	logic [SH_W-1:0]     dsh     [DIV_BITS];
	logic [DEN_W-1:0]    nxt_rem [DIV_BITS];
	logic [DIV_BITS-1:0] nxt_quo [DIV_BITS];
	logic [DEN_W-1:0]    rem0;

	// dividend carries half the divisor for rounding
	assign rem0 = (DEN_W'(1) << ONE_SHIFT) + (in_den >> 1);

	always_comb begin
		for (int j = 0; j < DIV_BITS; j++) begin
			if (j == 0) begin
				src_rem[j] = rem0;
				src_den[j] = in_den;
				src_quo[j] = '0;
			end else begin
				src_rem[j] = rem_s[j-1];
				src_den[j] = den_s[j-1];
				src_quo[j] = quo_s[j-1];
			end
			dsh[j] = SH_W'(src_den[j]) << (DIV_BITS - 1 - j);
			if (SH_W'(src_rem[j]) >= dsh[j]) begin
				nxt_rem[j] = src_rem[j] - dsh[j][DEN_W-1:0];
				nxt_quo[j] = src_quo[j] | (DIV_BITS'(1) << (DIV_BITS - 1 - j));
			end else begin
				nxt_rem[j] = src_rem[j];
				nxt_quo[j] = src_quo[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < DIV_BITS; j++) v_s[j] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int j = 1; j < DIV_BITS; j++) v_s[j] <= v_s[j-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s[0] <= in_geo;
			for (int j = 0; j < DIV_BITS; j++) begin
				rem_s[j] <= nxt_rem[j];
				den_s[j] <= src_den[j];
				quo_s[j] <= nxt_quo[j];
			end
			for (int j = 1; j < DIV_BITS; j++) geo_s[j] <= geo_s[j-1];
		end
	end

	assign out_valid = v_s[DIV_BITS-1];
	assign out_q     = quo_s[DIV_BITS-1];
	assign out_geo   = geo_s[DIV_BITS-1];

endmodule

// ----- rtl/wall_column_shader.sv -----
// ----------------------------------------------------------------------------
// wall_column_shader
// Shades one screen column of a wall face and emits its vertical segments.
// ----------------------------------------------------------------------------
// A column item enters the pipeline in any cycle in which the pipeline can
// advance; it spends three front stages, fifteen divider stages (one bit of
// the fade reciprocal each) and one gain stage, then waits in a head register
// from which one segment per cycle goes to the output register while the
// output is not stalled. Open edges give nothing, plain walls and edge lines
// give one segment, doors two or three.
module wall_column_shader (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [15:0]                   cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [11:0]                   column,
	input  logic signed [15:0]            top_row,
	input  logic signed [15:0]            bottom_row,
	input  logic [3:0]                    edge_kind,
	input  logic [15:0]                   view_distance,
	input  logic [15:0]                   wall_position,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [11:0]                   out_column,
	output logic [wcs_pkg::ROW_W-1:0]     seg_start_row,
	output logic [wcs_pkg::ROW_W-1:0]     seg_end_row,
	output logic [7:0]                    red,
	output logic [7:0]                    green,
	output logic [7:0]                    blue,
	output logic                          last_segment
);
	import wcs_pkg::*;

	localparam logic [22:0] RECIP_100 = 23'd5368710;

	logic [15:0]      fade_q, gain_q;
	logic [ROW_W-1:0] height_q, lim;

	logic adv, head_take, head_done, out_load, last_seg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_q   <= 16'd2214;
			gain_q   <= 16'd16384;
			height_q <= 13'd480;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FADE:   fade_q   <= cfg_data;
				CFG_GAIN:   gain_q   <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data[ROW_W-1:0];
				default:    ;
			endcase
		end
	end

	assign lim = (height_q > ROW_W'(MAX_HEIGHT)) ? ROW_W'(MAX_HEIGHT) : height_q;

	// ---------------- stage 1: fade product, position tests, row sums
	logic [16:0] d;
	logic [22:0] p100;
	logic [23:0] d100;
	logic [20:0] d10;
	logic signed [17:0] y0x, y1x;
	logic signed [23:0] y0w, y1w;

	assign p100 = 23'(wall_position) * 23'd100;
	assign d    = (wall_position > 16'd32768) ? 17'(wall_position) - 17'd32768
	                                          : 17'd32768 - 17'(wall_position);
	assign d10  = 21'(d) * 21'd10;
	assign d100 = 24'(d) * 24'd100;
	assign y0x  = 18'(top_row);
	assign y1x  = 18'(bottom_row);
	assign y0w  = 24'(top_row);
	assign y1w  = 24'(bottom_row);

	logic               v_s1;
	logic [31:0]        prod_s1;
	logic [11:0]        col_s1;
	logic signed [15:0] y0_s1, y1_s1;
	logic [3:0]         kind_s1;
	logic               edge_s1, band_s1, frame_s1;
	logic signed [17:0] se1_s1;
	logic signed [23:0] se2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1  <= 32'(fade_q) * 32'(view_distance);
			col_s1   <= column;
			y0_s1    <= top_row;
			y1_s1    <= bottom_row;
			kind_s1  <= edge_kind;
			edge_s1  <= (p100 < 23'd65536) || (p100 > 23'd6488064);
			band_s1  <= d10 <= 21'd196608;
			frame_s1 <= d100 > 24'd1703936;
			se1_s1   <= y0x * 18'sd3 + y1x;
			se2_s1   <= y0w * 24'sd71 + y1w * 24'sd29;
		end
	end

	// ---------------- stage 2: fade distance term, door split rows
	logic [32:0] prod_rnd;
	logic [44:0] e2_prod;
	assign prod_rnd = 33'(prod_s1) + 33'd128;
	assign e2_prod  = 45'(se2_s1[21:0]) * 45'(RECIP_100);

	logic               v_s2;
	logic [24:0]        t_s2;
	logic [11:0]        col_s2;
	logic signed [15:0] y0_s2, y1_s2;
	logic [3:0]         kind_s2;
	logic               edge_s2, band_s2, frame_s2;
	logic [15:0]        e1_s2, e2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s2     <= 25'(prod_rnd >> 8) + 25'd16384;
			col_s2   <= col_s1;
			y0_s2    <= y0_s1;
			y1_s2    <= y1_s1;
			kind_s2  <= kind_s1;
			edge_s2  <= edge_s1;
			band_s2  <= band_s1;
			frame_s2 <= frame_s1;
			// negative sums truncate toward zero and clamp to row 0 anyway
			e1_s2    <= (se1_s1 < 0) ? 16'd0 : se1_s1[17:2];
			e2_s2    <= (se2_s1 < 0) ? 16'd0 : e2_prod[44:29];
		end
	end

	// ---------------- stage 3: square, clamp rows, pick segment layout
	logic [3:0] kidx;
	mode_t      mode_c;
	assign kidx = kind_s2 - 4'd2;

	always_comb begin
		if (kind_s2 == 4'd0) mode_c = MODE_OPEN;
		else if (edge_s2) mode_c = MODE_EDGE;
		else if (kind_s2 == 4'd1 || !band_s2) mode_c = MODE_WALL;
		else if (frame_s2) mode_c = MODE_DOOR2;
		else mode_c = MODE_DOOR3;
	end

	logic             v_s3;
	logic [DEN_W-1:0] t2_s3;
	geo_t             geo_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t2_s3       <= DEN_W'(t_s2) * DEN_W'(t_s2);
			geo_s3.col  <= col_s2;
			geo_s3.top  <= clamp_row(18'(y0_s2), lim);
			geo_s3.bot  <= clamp_row(18'(y1_s2), lim);
			geo_s3.e1   <= clamp_row({2'b0, e1_s2}, lim);
			geo_s3.e2   <= clamp_row({2'b0, e2_s2}, lim);
			geo_s3.mode <= mode_c;
			geo_s3.idx  <= (kidx > 4'(DOOR_IDX_MAX)) ? 2'(DOOR_IDX_MAX) : kidx[1:0];
		end
	end

	// ---------------- stage 4: reciprocal of the squared term
	logic                dv_valid;
	logic [DIV_BITS-1:0] dv_q;
	geo_t                dv_geo;

	wcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s3),
		.in_den   (t2_s3),
		.in_geo   (geo_s3),
		.out_valid(dv_valid),
		.out_q    (dv_q),
		.out_geo  (dv_geo)
	);

	// ---------------- stage 5: limit and apply brightness gain
	logic [DIV_BITS-1:0] raw_lim;
	logic [31:0]         gained;
	assign raw_lim = (dv_q > DIV_BITS'(RATE_MAX)) ? DIV_BITS'(RATE_MAX) : dv_q;
	assign gained  = 32'(raw_lim) * 32'(gain_q) + 32'd8192;

	logic              v_s5;
	logic [RATE_W-1:0] rate_s5;
	geo_t              geo_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (adv) v_s5 <= dv_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rate_s5 <= gained[29:14];
			geo_s5  <= dv_geo;
		end
	end

	// ---------------- head register and segment sequencer
	logic              head_v_q;
	geo_t              head_geo_q;
	logic [RATE_W-1:0] head_rate_q;
	logic [1:0]        seg_q;

	logic [ROW_W-1:0] seg_start, seg_end;
	rgb_t             seg_rgb;

	assign out_load  = !out_valid || !out_stall;
	assign head_done = head_v_q && out_load && last_seg;
	assign head_take = !head_v_q || head_done;
	assign adv       = !v_s5 || head_take;
	assign in_stall  = !adv;

	always_comb begin
		seg_start = head_geo_q.top;
		seg_end   = head_geo_q.bot;
		seg_rgb   = '{r: 8'd255, g: 8'd0, b: 8'd0};
		last_seg  = 1'b1;
		case (head_geo_q.mode)
			MODE_EDGE: begin
				seg_rgb = '{r: 8'd230, g: 8'd0, b: 8'd0};
			end
			MODE_DOOR2, MODE_DOOR3: begin
				case (seg_q)
					2'd0: begin
						seg_end  = head_geo_q.e1;
						last_seg = 1'b0;
					end
					2'd1: begin
						seg_start = head_geo_q.e1;
						seg_rgb   = '{r: 8'd232, g: 8'd160, b: 8'd28};
						if (head_geo_q.mode == MODE_DOOR3) begin
							seg_end  = head_geo_q.e2;
							last_seg = 1'b0;
						end
					end
					default: begin
						seg_start = head_geo_q.e2;
						seg_rgb   = door_colour(head_geo_q.idx);
					end
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			seg_q    <= 2'd0;
		end else begin
			if (head_take) head_v_q <= v_s5 && (geo_s5.mode != MODE_OPEN);
			if (head_v_q && out_load) seg_q <= last_seg ? 2'd0 : seg_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (head_take) begin
			head_geo_q  <= geo_s5;
			head_rate_q <= rate_s5;
		end
	end

	// ---------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (out_load) out_valid <= head_v_q;
	end

	always_ff @(posedge clk) begin
		if (out_load && head_v_q) begin
			out_column    <= head_geo_q.col;
			seg_start_row <= seg_start;
			seg_end_row   <= seg_end;
			red           <= chan(seg_rgb.r, head_rate_q);
			green         <= chan(seg_rgb.g, head_rate_q);
			blue          <= chan(seg_rgb.b, head_rate_q);
			last_segment  <= last_seg;
		end
	end

endmodule

// ----- rtl/wcs_checker.sv -----
// ----------------------------------------------------------------------------
// wcs_checker
// Port-level checks on the segment output of the wall column shader.
// ----------------------------------------------------------------------------
module wcs_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [11:0]               out_column,
	input logic [wcs_pkg::ROW_W-1:0] seg_start_row,
	input logic [wcs_pkg::ROW_W-1:0] seg_end_row,
	input logic [7:0]                red,
	input logic [7:0]                green,
	input logic [7:0]                blue,
	input logic                      last_segment
);

	// a column's segments follow each other without gaps
	a_next_seg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_segment |=> out_valid)
		else $error("column segment missing after non-final segment");

	a_same_col: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_segment |=> out_column == $past(out_column))
		else $error("column changed inside one column's segments");

	a_rows_chain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_segment |=> seg_start_row == $past(seg_end_row))
		else $error("segment start does not meet previous segment end");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_column)
			&& $stable(seg_start_row) && $stable(seg_end_row) && $stable(red)
			&& $stable(green) && $stable(blue) && $stable(last_segment))
		else $error("stalled output item changed");

endmodule

bind wall_column_shader wcs_checker u_wcs_checker (.*);

// ----- tb/wall_column_shader_tb.sv -----
// ----------------------------------------------------------------------------
// wall_column_shader_tb
// Self-checking bench for the wall column shader. Directed columns cover the
// edge lines, plain wall, every door band, the colour kinds and the extremes of
// rows, distance and position. Random columns follow under several register
// settings and idle/stall mixes. Every segment is checked against a fade and
// geometry predictor kept in the bench.
// ----------------------------------------------------------------------------
module wall_column_shader_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wcs_pkg::*;

	typedef struct {
		logic [11:0]        col;
		logic signed [15:0] y0;
		logic signed [15:0] y1;
		logic [3:0]         kind;
		logic [15:0]        view_dist;
		logic [15:0]        pos;
	} column_item_t;

	typedef struct {
		logic [11:0]      col;
		logic [ROW_W-1:0] start_row;
		logic [ROW_W-1:0] end_row;
		logic [7:0]       r;
		logic [7:0]       g;
		logic [7:0]       b;
		logic             last;
	} segment_t;

	localparam int DRAIN_CYCLES = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = CFG_FADE;
	logic [15:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [11:0] column = '0;
	logic signed [15:0] top_row = '0;
	logic signed [15:0] bottom_row = '0;
	logic [3:0] edge_kind = '0;
	logic [15:0] view_distance = '0;
	logic [15:0] wall_position = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [11:0] out_column;
	logic [ROW_W-1:0] seg_start_row;
	logic [ROW_W-1:0] seg_end_row;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic last_segment;

	column_item_t pending_columns[$];
	segment_t expected_segments[$];
	column_item_t next_col;
	int idle_pct = 0;
	int stall_pct = 0;
	int errors = 0;

	// register shadows
	logic [15:0] fade_coef = 16'd2214;
	logic [15:0] gain = 16'd16384;
	logic [12:0] height = 13'd480;

	wall_column_shader DUT (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [15:0] fade_rate(input logic [15:0] view_dist);
		logic [63:0] t, t2, raw;
		t = ((64'(fade_coef) * 64'(view_dist) + 64'd128) >> 8) + 64'd16384;
		t2 = t * t;
		raw = ((64'd1 << 42) + (t2 >> 1)) / t2;
		if (raw > 64'(RATE_MAX)) raw = 64'(RATE_MAX);
		return 16'((raw * 64'(gain) + 64'd8192) >> 14);
	endfunction

	function automatic logic [7:0] shade(input int c, input logic [15:0] rate);
		longint v;
		v = (longint'(c) * longint'(rate) + 8192) >>> 14;
		return (v > 255) ? 8'd255 : 8'(v);
	endfunction

	function automatic logic [ROW_W-1:0] limit_row(input int y);
		int lim;
		lim = (height > MAX_HEIGHT) ? MAX_HEIGHT : int'(height);
		if (y < 0) return '0;
		if (y > lim) return ROW_W'(lim);
		return ROW_W'(y);
	endfunction

	function automatic void add_segment(input logic [11:0] col, input int s, input int e,
			input int r, input int g, input int b, input logic [15:0] rate,
			input logic last);
		segment_t sg;
		sg.col = col;
		sg.start_row = limit_row(s);
		sg.end_row = limit_row(e);
		sg.r = shade(r, rate);
		sg.g = shade(g, rate);
		sg.b = shade(b, rate);
		sg.last = last;
		expected_segments.insert(expected_segments.size(), sg);
	endfunction

	function automatic void shade_column(input column_item_t it);
		logic [15:0] rate;
		int y0, y1, d, e1, e2, k;
		longint p100;
		rate = fade_rate(it.view_dist);
		y0 = it.y0;
		y1 = it.y1;
		p100 = longint'(it.pos) * 100;
		d = (it.pos > 16'd32768) ? int'(it.pos) - 32768 : 32768 - int'(it.pos);
		if (it.kind == 4'd0) return;
		if (p100 < 65536 || p100 > 99 * 65536) begin
			add_segment(it.col, y0, y1, 230, 0, 0, rate, 1'b1);
			return;
		end
		if (it.kind == 4'd1 || d * 10 > 3 * 65536) begin
			add_segment(it.col, y0, y1, 255, 0, 0, rate, 1'b1);
			return;
		end
		e1 = (3 * y0 + y1) / 4;
		add_segment(it.col, y0, e1, 255, 0, 0, rate, 1'b0);
		if (d * 100 > 26 * 65536) begin
			add_segment(it.col, e1, y1, 232, 160, 28, rate, 1'b1);
			return;
		end
		e2 = (71 * y0 + 29 * y1) / 100;
		add_segment(it.col, e1, e2, 232, 160, 28, rate, 1'b0);
		k = int'(it.kind) - 2;
		if (k > DOOR_IDX_MAX) k = DOOR_IDX_MAX;
		case (k)
			0:       add_segment(it.col, e2, y1, 128, 86, 64, rate, 1'b1);
			1:       add_segment(it.col, e2, y1, 16, 28, 164, rate, 1'b1);
			2:       add_segment(it.col, e2, y1, 8, 160, 24, rate, 1'b1);
			default: add_segment(it.col, e2, y1, 180, 0, 0, rate, 1'b1);
		endcase
	endfunction

	// driver: predict on accept, then hold, advance or idle
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				shade_column('{column, top_row, bottom_row, edge_kind, view_distance,
					wall_position});
			if (!in_valid || !in_stall) begin
				if (pending_columns.size() > 0 && $urandom_range(99) >= idle_pct) begin
					next_col = pending_columns.pop_front();
					column <= next_col.col;
					top_row <= next_col.y0;
					bottom_row <= next_col.y1;
					edge_kind <= next_col.kind;
					view_distance <= next_col.view_dist;
					wall_position <= next_col.pos;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_segments.size() == 0) begin
					$error("segment with no column pending: column %0d", out_column);
					errors++;
				end else begin
					segment_t x;
					x = expected_segments.pop_front();
					if (out_column !== x.col) begin
						$error("out_column exp %0d got %0d", x.col, out_column); errors++;
					end
					if (seg_start_row !== x.start_row) begin
						$error("seg_start_row exp %0d got %0d", x.start_row, seg_start_row);
						errors++;
					end
					if (seg_end_row !== x.end_row) begin
						$error("seg_end_row exp %0d got %0d", x.end_row, seg_end_row);
						errors++;
					end
					if (red !== x.r) begin
						$error("red exp %0d got %0d", x.r, red); errors++;
					end
					if (green !== x.g) begin
						$error("green exp %0d got %0d", x.g, green); errors++;
					end
					if (blue !== x.b) begin
						$error("blue exp %0d got %0d", x.b, blue); errors++;
					end
					if (last_segment !== x.last) begin
						$error("last_segment exp %0d got %0d", x.last, last_segment);
						errors++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_FADE: fade_coef = val;
			CFG_GAIN: gain = val;
			default:  height = val[12:0];
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_column(input int col, input int y0, input int y1, input int kind,
			input int view_dist, input int pos);
		pending_columns.insert(pending_columns.size(), '{12'(col), 16'(y0), 16'(y1),
			4'(kind), 16'(view_dist), 16'(pos)});
	endtask

	task automatic queue_random(input int n);
		int y0, y1, pos, kind;
		repeat (n) begin
			case ($urandom_range(3))
				0: pos = $urandom_range(65535);
				1: pos = 32768 - 19700 + $urandom_range(39400);
				2: pos = 32768 - 17100 + $urandom_range(34200);
				default: pos = ($urandom_range(1)) ? $urandom_range(700) :
					64800 + $urandom_range(735);
			endcase
			if ($urandom_range(3) == 0) begin
				y0 = $urandom_range(65535);
				y1 = $urandom_range(65535);
			end else begin
				y0 = int'(height) / 2 - $urandom_range(600);
				y1 = int'(height) / 2 + $urandom_range(600);
			end
			kind = ($urandom_range(9) == 0) ? 0 : $urandom_range(15, 1);
			queue_column($urandom_range(4095), y0, y1, kind, $urandom_range(65535), pos);
		end
	endtask

	// hold the sender until every segment is out
	task automatic drain();
		while (pending_columns.size() > 0 || in_valid || expected_segments.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		write_reg(CFG_FADE, 16'd2214);
		write_reg(CFG_GAIN, 16'd16384);
		write_reg(CFG_HEIGHT, 16'd480);

		// directed: edges, wall, door bands, colour kinds, extremes
		queue_column(0, 100, 300, 1, 0, 0);
		queue_column(4095, 100, 300, 2, 65535, 655);
		queue_column(5, 100, 300, 1, 256, 656);
		queue_column(6, 100, 300, 1, 256, 64880);
		queue_column(7, 100, 300, 3, 256, 64881);
		queue_column(8, 100, 300, 0, 256, 0);
		queue_column(9, 100, 300, 0, 256, 32768);
		queue_column(10, 100, 300, 2, 512, 32768);
		queue_column(11, 100, 300, 3, 512, 32768);
		queue_column(12, 100, 300, 4, 512, 32768);
		queue_column(13, 100, 300, 5, 512, 32768);
		queue_column(14, 100, 300, 15, 512, 32768);
		queue_column(15, 100, 300, 2, 512, 32768 + 17039);
		queue_column(16, 100, 300, 2, 512, 32768 + 17040);
		queue_column(17, 100, 300, 2, 512, 32768 - 19660);
		queue_column(18, 100, 300, 2, 512, 32768 + 19661);
		queue_column(19, -32768, 32767, 2, 0, 32768);
		queue_column(20, 32767, -32768, 3, 0, 32768);
		queue_column(21, -7, -3, 4, 65535, 32768);
		queue_column(22, 470, 32767, 2, 100, 40000);
		queue_column(23, -1, 481, 1, 65535, 20000);
		drain();

		idle_pct = 82;
		write_reg(CFG_FADE, 16'd0);
		write_reg(CFG_GAIN, 16'd65535);
		queue_random(55);
		drain();

		idle_pct = 0;
		stall_pct = 82;
		write_reg(CFG_FADE, 16'd65535);
		write_reg(CFG_HEIGHT, 16'd4096);
		queue_random(55);
		drain();

		idle_pct = 12;
		stall_pct = 12;
		write_reg(CFG_GAIN, 16'd0);
		write_reg(CFG_HEIGHT, 16'd1);
		queue_random(55);
		drain();

		idle_pct = 0;
		stall_pct = 0;
		write_reg(CFG_FADE, 16'($urandom_range(4000)));
		write_reg(CFG_GAIN, 16'($urandom_range(65535)));
		write_reg(CFG_HEIGHT, 16'($urandom_range(4096, 1)));
		queue_random(55);
		drain();

		idle_pct = 30;
		stall_pct = 30;
		write_reg(CFG_GAIN, 16'd16384);
		write_reg(CFG_HEIGHT, 16'd480);
		queue_random(55);
		drain();

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#2ms;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
